// File: hdl/bps_pkg.sv
package bps_pkg;

  localparam int BYTE_W    = 8;
  localparam int BASE_W    = 48;
  localparam int ADDR_W    = 48;
  localparam int COUNT_W   = 32;
  localparam int LIMIT_W   = 32;
  localparam int LEN_W     = 6;
  localparam int WORD_W    = 64;
  localparam int PAT_WORDS = 4;
  localparam int PAT_BITS  = WORD_W * PAT_WORDS;
  localparam int PIDX_W    = 5;  // index of a byte in the 32-byte pattern store
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              region_start;
    logic              scan_start;
    logic [BASE_W-1:0] region_base;
  } bps_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  match_address;
    logic [COUNT_W-1:0] match_number;
    logic               limit_hit;
  } bps_out_t;

  // window control from the input stage
  typedef struct packed {
    logic              en;
    logic              new_region;
    logic [BYTE_W-1:0] data_byte;
  } bps_shift_t;

endpackage

// File: hdl/bps_cell.sv
module bps_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [bps_pkg::BYTE_W-1:0] byte_in,
  input  logic                       vld_in,
  input  logic [bps_pkg::BYTE_W-1:0] pat_byte,
  output logic [bps_pkg::BYTE_W-1:0] byte_out,
  output logic                       vld_out,
  output logic                       hit
);

  logic [bps_pkg::BYTE_W-1:0] byte_r;
  logic                       vld_r;

  // vld_r: the held byte belongs to the current region
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign vld_out  = vld_r;
  assign hit      = vld_r && (byte_r == pat_byte);

endmodule

// File: hdl/bps_window.sv
module bps_window #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bps_pkg::bps_shift_t          shift,
  input  logic [bps_pkg::PAT_BITS-1:0] pattern,
  input  logic [bps_pkg::LEN_W-1:0]    pattern_length,
  output logic                         match
);

  logic [bps_pkg::BYTE_W-1:0] cell_byte [MAX_PATTERN_BYTES];
  logic                       cell_vld  [MAX_PATTERN_BYTES];
  logic [bps_pkg::BYTE_W-1:0] aligned_r [MAX_PATTERN_BYTES];
  logic [bps_pkg::BYTE_W-1:0] aligned_nxt [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hit;
  logic [MAX_PATTERN_BYTES-1:0] in_use;
  logic                         len_ok;

  // cell 0 holds the newest byte; cell j must match pattern byte len-1-j
  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic [bps_pkg::BYTE_W-1:0] byte_in;
      logic                       vld_in;
      logic [bps_pkg::LEN_W-1:0]  pidx;

      if (j == 0) begin : g_head
        assign byte_in = shift.data_byte;
        assign vld_in  = 1'b1;
      end else begin : g_body
        assign byte_in = cell_byte[j-1];
        assign vld_in  = !shift.new_region && cell_vld[j-1];
      end

      assign pidx = pattern_length - bps_pkg::LEN_W'(1) - bps_pkg::LEN_W'(j);

      always_comb begin
        aligned_nxt[j] = pattern[{pidx[bps_pkg::PIDX_W-1:0], 3'b000} +: bps_pkg::BYTE_W];
      end

      always_ff @(posedge clk) begin
        aligned_r[j] <= aligned_nxt[j];
      end

      assign in_use[j] = bps_pkg::LEN_W'(j) < pattern_length;

      bps_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift.en),
        .byte_in  (byte_in),
        .vld_in   (vld_in),
        .pat_byte (aligned_r[j]),
        .byte_out (cell_byte[j]),
        .vld_out  (cell_vld[j]),
        .hit      (hit[j])
      );
    end
  endgenerate

  assign len_ok = (pattern_length != '0) &&
                  (pattern_length <= bps_pkg::LEN_W'(MAX_PATTERN_BYTES));
  assign match  = len_ok && (&(hit | ~in_use));

endmodule

// File: hdl/byte_pattern_scanner_core.sv
// An accepted byte passes the window cells and input stage registers, then the result register, before out_valid.
// Throughput: one byte per cycle; the match is a parallel compare across the
// cell row, and in_ready drops only while a held result is not taken.
// Reset (synchronous, rst_n low) clears the window, the match count, the
// address tracking and all configuration registers; no clearing pass.
module byte_pattern_scanner_core #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bps_pkg::bps_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bps_pkg::bps_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bps_pkg::WORD_W-1:0]      cfg_wdata
);

  // configuration
  logic [bps_pkg::PAT_BITS-1:0] pattern_r;
  logic [bps_pkg::LEN_W-1:0]    len_r;
  logic [bps_pkg::LIMIT_W-1:0]  limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= '0;
      limit_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::REG_PAT0:  pattern_r[0*bps_pkg::WORD_W +: bps_pkg::WORD_W] <= cfg_wdata;
        bps_pkg::REG_PAT1:  pattern_r[1*bps_pkg::WORD_W +: bps_pkg::WORD_W] <= cfg_wdata;
        bps_pkg::REG_PAT2:  pattern_r[2*bps_pkg::WORD_W +: bps_pkg::WORD_W] <= cfg_wdata;
        bps_pkg::REG_PAT3:  pattern_r[3*bps_pkg::WORD_W +: bps_pkg::WORD_W] <= cfg_wdata;
        bps_pkg::REG_LEN:   len_r   <= cfg_wdata[bps_pkg::LEN_W-1:0];
        bps_pkg::REG_LIMIT: limit_r <= cfg_wdata[bps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic adv;
  logic accept;
  logic new_region;

  assign adv        = !out_valid || out_ready;
  assign in_ready   = adv;
  assign accept     = in_valid && adv;
  assign new_region = in_data.region_start || in_data.scan_start;

  // input stage: address tracking and window shift
  logic [bps_pkg::ADDR_W-1:0] addr_r;
  logic [bps_pkg::ADDR_W-1:0] this_addr;
  logic [bps_pkg::ADDR_W-1:0] b_addr_r;
  logic                       b_vld_r;
  logic                       b_scan_r;
  bps_pkg::bps_shift_t        shift;

  assign this_addr = new_region ? bps_pkg::ADDR_W'(in_data.region_base) : addr_r;

  always_comb begin
    shift.en         = accept;
    shift.new_region = new_region;
    shift.data_byte  = in_data.data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= accept;
      if (accept) begin
        addr_r <= this_addr + bps_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr_r <= this_addr;
      b_scan_r <= in_data.scan_start;
    end
  end

  logic match;

  bps_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .shift          (shift),
    .pattern        (pattern_r),
    .pattern_length (len_r),
    .match          (match)
  );

  // match stage: count, limit, result register
  logic [bps_pkg::COUNT_W-1:0] found_r;
  logic [bps_pkg::COUNT_W-1:0] found_nxt;
  logic [bps_pkg::COUNT_W-1:0] found_base;
  logic [bps_pkg::COUNT_W-1:0] found_inc;
  logic [bps_pkg::COUNT_W-1:0] limit_ext;
  logic                        limit_on;
  logic                        blocked;
  logic                        report;
  logic                        out_vld_r;
  logic                        out_vld_nxt;
  bps_pkg::bps_out_t           out_r;
  bps_pkg::bps_out_t           out_nxt;

  assign limit_ext  = bps_pkg::COUNT_W'(limit_r);
  assign limit_on   = limit_r != '0;
  assign found_base = b_scan_r ? '0 : found_r;
  assign blocked    = limit_on && (found_base >= limit_ext);
  assign report     = b_vld_r && match && !blocked;
  // saturate at the counter's maximum
  assign found_inc  = (found_base != '1) ? found_base + bps_pkg::COUNT_W'(1) : found_base;

  always_comb begin
    found_nxt   = found_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (adv) begin
      out_vld_nxt = report;
      if (b_vld_r) begin
        found_nxt = report ? found_inc : found_base;
      end
      if (report) begin
        out_nxt.match_address = b_addr_r + bps_pkg::ADDR_W'(1) - bps_pkg::ADDR_W'(len_r);
        out_nxt.match_number  = found_inc;
        out_nxt.limit_hit     = limit_on && (found_inc >= limit_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      found_r   <= found_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
